FILE: sv/two_class_exclusive_admission_assert.svh
// Assertion macros used by the datapath RTL file.
`ifndef TWO_CLASS_EXCLUSIVE_ADMISSION_ASSERT_SVH
`define TWO_CLASS_EXCLUSIVE_ADMISSION_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define TCEA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("admission check failed");
// Next-cycle implication, disabled while reset is low.
`define TCEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("admission check failed");
`else
`define TCEA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TCEA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/tcea_pkg.sv
`default_nettype none
package tcea_pkg;

	// Input op codes
	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_DEPART = 1'b1;

	// Result outcome codes
	localparam logic [2:0] OUT_QUEUED   = 3'd0;
	localparam logic [2:0] OUT_ADMITTED = 3'd1;
	localparam logic [2:0] OUT_WOKEN    = 3'd2;
	localparam logic [2:0] OUT_NOTHING  = 3'd3;
	localparam logic [2:0] OUT_ERROR    = 3'd4;

	// Register indexes
	localparam logic REG_CAPACITY     = 1'b0;
	localparam logic REG_STREAK_LIMIT = 1'b1;

	// Results per input item and the width of their count
	localparam int RESULT_LIMIT = 17;
	localparam int CNT_W = 5;

	// Saturation limits of the counters
	localparam logic [7:0] STREAK_MAX = 8'd255;
	localparam logic [4:0] INSIDE_MAX = 5'd31;

	// Reset values of the registers
	localparam logic [4:0] CAPACITY_RST     = 5'd2;
	localparam logic [7:0] STREAK_LIMIT_RST = 8'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CHAIN
	} ctl_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic eval;
		logic chain;
	} tcea_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic slot_free;
		logic eval_final;
		logic chain_more;
	} tcea_sts_t;

endpackage
`default_nettype wire

FILE: sv/tcea_ctrl.sv
`default_nettype none
module tcea_ctrl
	import tcea_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  tcea_sts_t      sts,
	output tcea_cmd_t      cmd
);

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.slot_free) begin
					state_nxt = sts.eval_final ? ST_IDLE : ST_CHAIN;
				end
			end
			ST_CHAIN: begin
				if (sts.slot_free && !sts.chain_more) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EVAL: begin
				cmd.eval = sts.slot_free;
			end
			ST_CHAIN: begin
				cmd.chain = sts.slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/tcea_datapath.sv
`default_nettype none
`include "two_class_exclusive_admission_assert.svh"
module tcea_datapath
	import tcea_pkg::*;
#(
	parameter int MAX_CAPACITY = 16,
	parameter int MAX_WAITING  = 255
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  tcea_cmd_t       cmd,
	output tcea_sts_t       sts,
	input  wire logic       in_op,
	input  wire logic       in_class,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      out_outcome,
	output logic            out_class,
	output logic            out_last
);

	localparam int WAIT_W = $clog2(MAX_WAITING + 1);
	localparam logic [WAIT_W-1:0] WAIT_FULL = WAIT_W'(MAX_WAITING);

	// Configuration
	logic [4:0] capacity_q;
	logic [7:0] streak_limit_q;
	logic [4:0] eff_cap;

	// Admission state
	logic [WAIT_W-1:0] waiting_q [2];
	logic [4:0]        inside_q [2];
	logic [7:0]        streak_q;
	logic [WAIT_W-1:0] waiting_nxt [2];
	logic [4:0]        inside_nxt [2];
	logic [7:0]        streak_nxt;

	// Current item and pending result
	logic             op_q;
	logic             cls_q;
	logic             chain_cls_q;
	logic [2:0]       pend_outcome_q;
	logic [CNT_W-1:0] cnt_q;

	// Output register
	logic       out_valid_q;
	logic [2:0] out_outcome_q;
	logic       out_class_q;
	logic       out_last_q;

	// Per-step results
	logic       push;
	logic [2:0] push_outcome;
	logic       push_class;
	logic       push_last;
	logic       set_pend;
	logic [2:0] pend_outcome_nxt;
	logic       chain_cls_nxt;
	logic       eval_final;
	logic       chain_more;

	// Evaluation locals
	logic       c;
	logic       o;
	logic       k;
	logic       ko;
	logic       blocked;
	logic [4:0] ins_dec;
	logic [7:0] streak_inc;
	logic [4:0] ins_inc;

	assign eff_cap = (32'(capacity_q) < MAX_CAPACITY) ? capacity_q : 5'(MAX_CAPACITY);

	// Evaluate the item or one wake step
	always_comb begin
		c                = cls_q;
		o                = ~cls_q;
		k                = chain_cls_q;
		ko               = ~chain_cls_q;
		waiting_nxt      = waiting_q;
		inside_nxt       = inside_q;
		streak_nxt       = streak_q;
		push             = 1'b0;
		push_outcome     = OUT_NOTHING;
		push_class       = cls_q;
		push_last        = 1'b1;
		set_pend         = 1'b0;
		pend_outcome_nxt = OUT_ADMITTED;
		chain_cls_nxt    = cls_q;
		eval_final       = 1'b1;
		blocked = (inside_q[o] != 5'd0) || (inside_q[c] >= eff_cap) ||
			(streak_q >= streak_limit_q);
		ins_dec = inside_q[c] - 5'd1;

		// First result of the item
		if (op_q == OP_ARRIVE) begin
			if (blocked) begin
				if (waiting_q[c] >= WAIT_FULL) begin
					push_outcome = OUT_ERROR;
				end else begin
					push_outcome = OUT_QUEUED;
					waiting_nxt[c] = waiting_q[c] + WAIT_W'(1);
				end
			end else begin
				eval_final       = 1'b0;
				pend_outcome_nxt = OUT_ADMITTED;
				chain_cls_nxt    = c;
			end
		end else begin
			if (inside_q[c] == 5'd0) begin
				push_outcome = OUT_ERROR;
			end else begin
				inside_nxt[c] = ins_dec;
				if ((waiting_q[c] != '0) && (streak_q < streak_limit_q)) begin
					waiting_nxt[c]   = waiting_q[c] - WAIT_W'(1);
					eval_final       = 1'b0;
					pend_outcome_nxt = OUT_WOKEN;
					chain_cls_nxt    = c;
				end else if ((ins_dec == 5'd0) && (waiting_q[o] != '0)) begin
					streak_nxt       = 8'd0;
					waiting_nxt[o]   = waiting_q[o] - WAIT_W'(1);
					eval_final       = 1'b0;
					pend_outcome_nxt = OUT_WOKEN;
					chain_cls_nxt    = o;
				end else begin
					if (ins_dec == 5'd0) begin
						streak_nxt = 8'd0;
					end
					push_outcome = OUT_NOTHING;
				end
			end
		end
		if (cmd.eval) begin
			push     = eval_final;
			set_pend = !eval_final;
		end

		// One wake step of the chain
		streak_inc = ((waiting_q[ko] != '0) && (streak_q != STREAK_MAX)) ?
			streak_q + 8'd1 : streak_q;
		ins_inc = (inside_q[k] != INSIDE_MAX) ? inside_q[k] + 5'd1 : inside_q[k];
		chain_more = (waiting_q[k] != '0) && (streak_inc < streak_limit_q) &&
			(ins_inc < eff_cap) && (32'(cnt_q) < RESULT_LIMIT);

		if (!cmd.eval) begin
			waiting_nxt = waiting_q;
			inside_nxt  = inside_q;
			streak_nxt  = streak_q;
		end
		if (cmd.chain) begin
			streak_nxt  = streak_inc;
			inside_nxt[k] = ins_inc;
			push         = 1'b1;
			push_outcome = pend_outcome_q;
			push_class   = k;
			push_last    = !chain_more;
			if (chain_more) begin
				waiting_nxt[k]   = waiting_q[k] - WAIT_W'(1);
				set_pend         = 1'b1;
				pend_outcome_nxt = OUT_WOKEN;
				chain_cls_nxt    = k;
			end
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q     <= CAPACITY_RST;
			streak_limit_q <= STREAK_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CAPACITY:     capacity_q     <= cfg_data[4:0];
				REG_STREAK_LIMIT: streak_limit_q <= cfg_data;
				default:          capacity_q     <= capacity_q;
			endcase
		end
	end

	// Update admission state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q[0] <= '0;
			waiting_q[1] <= '0;
			inside_q[0]  <= '0;
			inside_q[1]  <= '0;
			streak_q     <= '0;
			cnt_q        <= '0;
		end else begin
			waiting_q <= waiting_nxt;
			inside_q  <= inside_nxt;
			streak_q  <= streak_nxt;
			if (cmd.eval) begin
				cnt_q <= CNT_W'(1);
			end else if (cmd.chain && chain_more) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Capture the item and hold the pending result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			cls_q <= in_class;
		end
		if (set_pend) begin
			pend_outcome_q <= pend_outcome_nxt;
			chain_cls_q    <= chain_cls_nxt;
		end
	end

	// Output register: load on push, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_outcome_q <= push_outcome;
			out_class_q   <= push_class;
			out_last_q    <= push_last;
		end
	end

	assign sts.slot_free  = !out_valid_q || out_ready;
	assign sts.eval_final = eval_final;
	assign sts.chain_more = chain_more;

	assign out_valid   = out_valid_q;
	assign out_outcome = out_outcome_q;
	assign out_class   = out_class_q;
	assign out_last    = out_last_q;

	`TCEA_ASSERT_IMPLY(a_one_class_inside, clk, arst_n, 1'b1,
		(inside_q[0] == 5'd0) || (inside_q[1] == 5'd0))
	`TCEA_ASSERT_IMPLY(a_push_into_free_slot, clk, arst_n, push, !out_valid_q || out_ready)
	`TCEA_ASSERT_IMPLY(a_result_count_bound, clk, arst_n, 1'b1, 32'(cnt_q) <= RESULT_LIMIT)
	`TCEA_ASSERT_NEXT(a_chain_step_counted, clk, arst_n, cmd.chain && chain_more,
		cnt_q == $past(cnt_q) + CNT_W'(1))

endmodule
`default_nettype wire

FILE: sv/two_class_exclusive_admission.sv
`default_nettype none
// Channel   Direction  Signals                     Content
// s         in         s_tvalid/s_tready           tdata[0] requester_class, tuser[0] op
// m         out        m_tvalid/m_tready           tdata[2:0] outcome, tdata[3] grant_class,
//                                                  tlast last
// cfg       in         cfg_wr_en                   cfg_index 0 capacity, 1 streak_limit
//
// One item at a time: the controller accepts an item, then evaluates it. A queued,
// error or nothing result is loaded at the evaluation; an admission or a wake loads
// each of its N results (N at most 17) on a chain step of its own.
// A stalled output holds the controller in place; the next item is accepted
// while the last result of the previous one still waits in the output register.
// Reset clears the counters and loads capacity 2 and streak_limit 4.
module two_class_exclusive_admission
	import tcea_pkg::*;
#(
	parameter int MAX_CAPACITY = 16,
	parameter int MAX_WAITING  = 255
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [0] requester_class
	input  wire logic [0:0] s_tuser,   // [0] op
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [2:0] outcome, [3] grant_class
	output logic            m_tlast,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	tcea_cmd_t  cmd;
	tcea_sts_t  sts;
	logic [2:0] outcome;
	logic       grant_class;

	tcea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcea_datapath #(
		.MAX_CAPACITY (MAX_CAPACITY),
		.MAX_WAITING  (MAX_WAITING)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_op       (s_tuser[0]),
		.in_class    (s_tdata[0]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_outcome (outcome),
		.out_class   (grant_class),
		.out_last    (m_tlast)
	);

	// Pack the result fields
	assign m_tdata = {4'b0000, grant_class, outcome};

endmodule
`default_nettype wire

FILE: bench/tb_two_class_exclusive_admission.sv
`timescale 1ns / 1ps

module tb_two_class_exclusive_admission;
	import tcea_pkg::*;

	localparam int CAP_BOUND = 16;
	localparam int QUEUE_DEPTH = 255;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 40;
	localparam int NUM_SETTINGS = 8;
	localparam int RANDOM_PER_SETTING = 5;

	// One expected grant result
	typedef struct packed {
		logic [2:0] outcome;
		logic       grant_class;
		logic       last;
	} grant_t;

	// Tracks occupancy, queues and streak, and the grant results still due
	class admission_tracker;
		logic [4:0] capacity;
		logic [7:0] streak_limit;
		logic [7:0] waiting[2];
		logic [4:0] occupancy[2];
		logic [7:0] streak;
		grant_t     burst[$];
		grant_t     grants_due[$];
		int         requests;
		int         checked;
		int         wakes;
		int         errors_seen;
		int         failures;

		function new();
			capacity = CAPACITY_RST;
			streak_limit = STREAK_LIMIT_RST;
			waiting[0] = '0;
			waiting[1] = '0;
			occupancy[0] = '0;
			occupancy[1] = '0;
			streak = '0;
			requests = 0;
			checked = 0;
			wakes = 0;
			errors_seen = 0;
			failures = 0;
		endfunction

		function void set_reg(logic idx, logic [7:0] val);
			if (idx == REG_CAPACITY)
				capacity = val[4:0];
			else
				streak_limit = val;
		endfunction

		function int eff_cap();
			return (capacity < CAP_BOUND) ? int'(capacity) : CAP_BOUND;
		endfunction

		function void emit(logic [2:0] outcome, logic cls);
			grant_t g;
			g.outcome = outcome;
			g.grant_class = cls;
			g.last = 1'b0;
			burst.push_back(g);
			if (outcome == OUT_WOKEN)
				wakes++;
			if (outcome == OUT_ERROR)
				errors_seen++;
		endfunction

		// Admit one of class c, then wake same-class waiters while allowed
		function void admit_chain(logic c);
			logic o;
			o = ~c;
			while (1) begin
				if (waiting[o] > 0 && streak < STREAK_MAX)
					streak++;
				if (occupancy[c] < INSIDE_MAX)
					occupancy[c]++;
				if (waiting[c] > 0 && streak < streak_limit && occupancy[c] < eff_cap() &&
				    burst.size() < RESULT_LIMIT) begin
					waiting[c]--;
					emit(OUT_WOKEN, c);
				end else begin
					break;
				end
			end
		endfunction

		// Work out the grant results of one accepted request
		function void note_request(logic op, logic c);
			logic o;
			logic blocked;
			o = ~c;
			burst.delete();
			requests++;
			if (op == OP_ARRIVE) begin
				blocked = occupancy[o] > 0 || occupancy[c] >= eff_cap() ||
					streak >= streak_limit;
				if (!blocked) begin
					emit(OUT_ADMITTED, c);
					admit_chain(c);
				end else if (waiting[c] >= QUEUE_DEPTH) begin
					emit(OUT_ERROR, c);
				end else begin
					waiting[c]++;
					emit(OUT_QUEUED, c);
				end
			end else if (occupancy[c] == 0) begin
				emit(OUT_ERROR, c);
			end else begin
				occupancy[c]--;
				if (waiting[c] > 0 && streak < streak_limit) begin
					waiting[c]--;
					emit(OUT_WOKEN, c);
					admit_chain(c);
				end else if (occupancy[c] == 0 && waiting[o] > 0) begin
					// hand over to the other class
					streak = '0;
					waiting[o]--;
					emit(OUT_WOKEN, o);
					admit_chain(o);
				end else begin
					if (occupancy[c] == 0)
						streak = '0;
					emit(OUT_NOTHING, c);
				end
			end
			burst[burst.size() - 1].last = 1'b1;
			foreach (burst[i])
				grants_due.push_back(burst[i]);
		endfunction

		// Compare one accepted grant result with the oldest one due
		function void check_grant(logic [2:0] outcome, logic cls, logic last);
			grant_t want;
			if (grants_due.size() == 0) begin
				$display("%0t: unexpected result outcome %0d class %0d last %0d",
					$time, outcome, cls, last);
				failures++;
				return;
			end
			want = grants_due.pop_front();
			checked++;
			if (want.outcome !== outcome || want.grant_class !== cls || want.last !== last) begin
				$display("%0t: mismatch expected outcome %0d class %0d last %0d, got %0d %0d %0d",
					$time, want.outcome, want.grant_class, want.last, outcome, cls, last);
				failures++;
			end
		endfunction

		function int pending();
			return grants_due.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [0] requester_class
	logic [0:0] s_tuser;   // [0] op
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [2:0] outcome, [3] grant_class
	logic       m_tlast;
	logic       cfg_wr_en;
	logic       cfg_index;
	logic [7:0] cfg_data;

	admission_tracker tracker;
	int idle_pct;
	int stall_pct;
	int cycle_count = 0;
	int settings_done = 0;

	two_class_exclusive_admission #(
		.MAX_CAPACITY(CAP_BOUND),
		.MAX_WAITING(QUEUE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Check every accepted result transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_grant(m_tdata[2:0], m_tdata[3], m_tlast);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("two_class_exclusive_admission test failed");
			$finish;
		end
	end

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 57;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 57;
			end
			default: begin
				idle_pct = 33;
				stall_pct = 33;
			end
		endcase
	endtask

	// Present one request and hold it until the transaction completes
	task automatic send_request(input logic op, input logic cls);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, cls};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		tracker.note_request(op, cls);
	endtask

	// Write one register once every result due has been taken
	task automatic write_reg(input logic idx, input logic [7:0] val);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
		cfg_wr_en <= 1'b0;
		settings_done++;
	endtask

	// Mostly well-formed traffic: depart a present class, or arrive of either class
	task automatic send_random();
		int r;
		logic op;
		logic cls;
		logic present;
		r = $urandom_range(0, 99);
		op = 1'($urandom_range(0, 1));
		cls = 1'($urandom_range(0, 1));
		present = (tracker.occupancy[1] > 0);
		if (r >= 15) begin
			if (tracker.occupancy[0] == 0 && tracker.occupancy[1] == 0) begin
				op = OP_ARRIVE;
			end else if (r < 55) begin
				op = OP_DEPART;
				cls = present;
			end else begin
				op = OP_ARRIVE;
				cls = (r < 78) ? present : ~present;
			end
		end
		send_request(op, cls);
	endtask

	// Empty the resource and both queues
	task automatic drain_resource();
		int guard;
		guard = 0;
		while ((tracker.occupancy[0] != 0 || tracker.occupancy[1] != 0 ||
		        tracker.waiting[0] != 0 || tracker.waiting[1] != 0) && guard < 2000) begin
			if (tracker.occupancy[0] != 0)
				send_request(OP_DEPART, 1'b0);
			else if (tracker.occupancy[1] != 0)
				send_request(OP_DEPART, 1'b1);
			else if (tracker.waiting[0] != 0)
				send_request(OP_ARRIVE, 1'b0);
			else
				send_request(OP_ARRIVE, 1'b1);
			guard++;
		end
	endtask

	initial begin
		int cap_set[NUM_SETTINGS];
		int lim_set[NUM_SETTINGS];
		cap_set = '{1, 16, 0, 31, 5, 3, 16, 2};
		lim_set = '{1, 255, 4, 0, 2, 255, 1, 4};
		tracker = new();
		set_idling(0);
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		m_tready <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_CAPACITY;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: departures when empty, capacity full, queuing, wakes, hand-over
		send_request(OP_DEPART, 1'b0);
		send_request(OP_DEPART, 1'b1);
		send_request(OP_ARRIVE, 1'b0);
		send_request(OP_ARRIVE, 1'b0);
		send_request(OP_ARRIVE, 1'b0);
		send_request(OP_ARRIVE, 1'b1);
		send_request(OP_ARRIVE, 1'b1);
		send_request(OP_ARRIVE, 1'b1);
		send_request(OP_DEPART, 1'b0);
		send_request(OP_ARRIVE, 1'b0);
		send_request(OP_DEPART, 1'b0);
		send_request(OP_DEPART, 1'b0);
		send_request(OP_DEPART, 1'b0);
		send_request(OP_ARRIVE, 1'b0);
		send_request(OP_ARRIVE, 1'b0);
		send_request(OP_DEPART, 1'b1);
		send_request(OP_DEPART, 1'b1);
		send_request(OP_ARRIVE, 1'b1);
		send_request(OP_DEPART, 1'b1);
		send_request(OP_DEPART, 1'b1);
		send_request(OP_DEPART, 1'b0);
		send_request(OP_DEPART, 1'b0);
		send_request(OP_DEPART, 1'b0);
		send_request(OP_DEPART, 1'b1);

		// Random traffic over a sweep of settings and idling patterns
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			set_idling(p % 4);
			write_reg(REG_CAPACITY, {3'($urandom_range(0, 7)), 5'(cap_set[p])});
			write_reg(REG_STREAK_LIMIT, 8'(lim_set[p]));
			repeat (RANDOM_PER_SETTING) send_random();
		end

		// Largest settings: fill one queue past its depth under every idling pattern
		write_reg(REG_CAPACITY, 8'd16);
		write_reg(REG_STREAK_LIMIT, 8'd255);
		set_idling(0);
		drain_resource();
		send_request(OP_ARRIVE, 1'b0);
		for (int q = 0; q < 4; q++) begin
			set_idling(q);
			repeat ((QUEUE_DEPTH + 1) / 4) send_request(OP_ARRIVE, 1'b1);
		end

		// Let the last results come out, then allow for stragglers
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests over %0d register writes: %0d results checked",
			tracker.requests, settings_done, tracker.checked);
		$display("including %0d wakes and %0d error results", tracker.wakes,
			tracker.errors_seen);
		if (tracker.failures == 0)
			$display("two_class_exclusive_admission test passed");
		else
			$display("two_class_exclusive_admission test failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/tcea_pkg.sv
sv/tcea_ctrl.sv
sv/tcea_datapath.sv
sv/two_class_exclusive_admission.sv
bench/tb_two_class_exclusive_admission.sv
